// ----- src/jet_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the escape-time block.
// No dependencies; every other file but jet_checker imports this package.
package jet_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 28;
	localparam int PROD_W = 64;
	localparam int LIM_W  = 11;
	localparam int EXP_W  = 4;
	localparam int IDX_W  = 12;
	localparam int STEP_W = 31;
	localparam int ADDR_W = 5;
	localparam int JCNT_W = 5;

	// |z|^2 bound of 4 in Q8.56
	localparam logic [PROD_W-1:0] RADIUS_SQ = 64'h0400_0000_0000_0000;
	localparam logic [JCNT_W-1:0] MIN_POWER = 5'd2;

	localparam logic [LIM_W-1:0]  RST_LIMIT = 11'd50;
	localparam logic [EXP_W-1:0]  RST_EXP   = 4'd2;
	localparam logic [STEP_W-1:0] RST_STEP  = 31'd2684355;

	localparam logic [2:0] REG_LIMIT    = 3'd0;
	localparam logic [2:0] REG_EXPONENT = 3'd1;
	localparam logic [2:0] REG_CONST_RE = 3'd2;
	localparam logic [2:0] REG_CONST_IM = 3'd3;
	localparam logic [2:0] REG_ORIGIN_X = 3'd4;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd5;
	localparam logic [2:0] REG_STEP     = 3'd6;

	typedef enum logic [2:0] {
		MUL_COL_STEP,
		MUL_ROW_STEP,
		MUL_RR,
		MUL_II,
		MUL_PR_ZR,
		MUL_PI_ZI,
		MUL_PR_ZI,
		MUL_PI_ZR
	} jet_mul_sel_t;

	typedef struct packed {
		jet_mul_sel_t mul_sel;
		logic         cap;
		logic         zr_start;
		logic         zi_start;
		logic         acc_ld;
		logic         test;
		logic         p_copy;
		logic         tr_ld;
		logic         p_ld;
		logic         z_upd;
		logic         res_ld;
	} jet_cmd_t;

	typedef struct packed {
		logic in_radius;
		logic at_limit;
	} jet_stat_t;

endpackage

// ----- src/julia_escape_time_power_n_top.sv -----
`timescale 1ns / 1ps
// Escape-time iteration of z -> z^n + c for one pixel per request, Q4.28 fixed point.
// Input channel: in_valid/in_ready with pixel_col, pixel_row. Output channel:
// out_valid/out_ready with escape_index, escaped, final_re, final_im.
// Registers sit behind an APB-style port (4-byte stride, pready tied high);
// write them only while no request is in flight.
// One request at a time. With effective power n, each update of z runs the escape
// test (S_TS0 to S_TS2), (n-1) complex products (S_M0 to S_M4 each) on the single
// shared 32x32 multiplier, and S_UPD to add c. The next request can be taken as
// soon as the result is valid.
// A finished result waits in the output register; the next request is accepted
// and worked on meanwhile, and its own result holds in the sequencer until the
// receiver takes the pending one.
// Reset restores the register defaults and empties the output register.
// Depends on jet_pkg, jet_regs, jet_ctrl and jet_dp.
module julia_escape_time_power_n_top import jet_pkg::*; #(
	parameter int LIMIT_MAX  = 1024,
	parameter int MAX_POWER  = 8,
	parameter int COORD_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [COORD_BITS-1:0]    pixel_col,
	input  logic [COORD_BITS-1:0]    pixel_row,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [IDX_W-1:0]  escape_index,
	output logic                     escaped,
	output logic signed [DATA_W-1:0] final_re,
	output logic signed [DATA_W-1:0] final_im
);

	logic [LIM_W-1:0]         iteration_limit;
	logic [EXP_W-1:0]         exponent;
	logic signed [DATA_W-1:0] const_re, const_im, origin_x, origin_y;
	logic [STEP_W-1:0]        pixel_step;
	jet_cmd_t                 cmd;
	jet_stat_t                stat;

	jet_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.iteration_limit (iteration_limit),
		.exponent        (exponent),
		.const_re        (const_re),
		.const_im        (const_im),
		.origin_x        (origin_x),
		.origin_y        (origin_y),
		.pixel_step      (pixel_step)
	);

	jet_ctrl #(
		.MAX_POWER (MAX_POWER)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.exponent  (exponent),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	jet_dp #(
		.COORD_BITS (COORD_BITS),
		.LIMIT_MAX  (LIMIT_MAX)
	) u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.stat            (stat),
		.pixel_col       (pixel_col),
		.pixel_row       (pixel_row),
		.iteration_limit (iteration_limit),
		.const_re        (const_re),
		.const_im        (const_im),
		.origin_x        (origin_x),
		.origin_y        (origin_y),
		.pixel_step      (pixel_step),
		.escape_index    (escape_index),
		.escaped         (escaped),
		.final_re        (final_re),
		.final_im        (final_im)
	);

endmodule

// ----- src/jet_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on jet_pkg for widths, reset values and register indexes.
module jet_regs import jet_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	output logic [LIM_W-1:0]         iteration_limit,
	output logic [EXP_W-1:0]         exponent,
	output logic signed [DATA_W-1:0] const_re,
	output logic signed [DATA_W-1:0] const_im,
	output logic signed [DATA_W-1:0] origin_x,
	output logic signed [DATA_W-1:0] origin_y,
	output logic [STEP_W-1:0]        pixel_step
);

	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iteration_limit <= RST_LIMIT;
			exponent        <= RST_EXP;
			const_re        <= '0;
			const_im        <= '0;
			origin_x        <= '0;
			origin_y        <= '0;
			pixel_step      <= RST_STEP;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LIMIT:    iteration_limit <= pwdata[LIM_W-1:0];
				REG_EXPONENT: exponent        <= pwdata[EXP_W-1:0];
				REG_CONST_RE: const_re        <= pwdata;
				REG_CONST_IM: const_im        <= pwdata;
				REG_ORIGIN_X: origin_x        <= pwdata;
				REG_ORIGIN_Y: origin_y        <= pwdata;
				REG_STEP:     pixel_step      <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LIMIT:    prdata = DATA_W'(iteration_limit);
			REG_EXPONENT: prdata = DATA_W'(exponent);
			REG_CONST_RE: prdata = const_re;
			REG_CONST_IM: prdata = const_im;
			REG_ORIGIN_X: prdata = origin_x;
			REG_ORIGIN_Y: prdata = origin_y;
			REG_STEP:     prdata = DATA_W'(pixel_step);
			default:      prdata = '0;
		endcase
	end

endmodule

// ----- src/jet_dp.sv -----
`timescale 1ns / 1ps
// Datapath: shared 32x32 multiplier, accumulator, z and partial-power registers,
// iteration counter and result register. Depends on jet_pkg; driven by jet_ctrl.
module jet_dp import jet_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int LIMIT_MAX  = 1024
) (
	input  logic                     clk,
	input  jet_cmd_t                 cmd,
	output jet_stat_t                stat,
	input  logic [COORD_BITS-1:0]    pixel_col,
	input  logic [COORD_BITS-1:0]    pixel_row,
	input  logic [LIM_W-1:0]         iteration_limit,
	input  logic signed [DATA_W-1:0] const_re,
	input  logic signed [DATA_W-1:0] const_im,
	input  logic signed [DATA_W-1:0] origin_x,
	input  logic signed [DATA_W-1:0] origin_y,
	input  logic [STEP_W-1:0]        pixel_step,
	output logic signed [IDX_W-1:0]  escape_index,
	output logic                     escaped,
	output logic signed [DATA_W-1:0] final_re,
	output logic signed [DATA_W-1:0] final_im
);

	localparam logic [16:0] LIMIT_MAX_W = 17'(LIMIT_MAX);

	logic [COORD_BITS-1:0]    col_q, row_q;
	logic signed [DATA_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_c;
	logic [PROD_W-1:0]        prod_s1;
	logic [PROD_W-1:0]        acc_q;
	logic [PROD_W-1:0]        sum_c, diff_c;
	logic [DATA_W-1:0]        zr_q, zi_q, pr_q, pi_q, tr_q;
	logic [LIM_W-1:0]         cnt_q, lim_eff;
	logic                     in_radius_q;

	assign lim_eff = ({6'd0, iteration_limit} > LIMIT_MAX_W) ? LIMIT_MAX_W[LIM_W-1:0]
		: iteration_limit;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_COL_STEP: begin
				mul_a = signed'(DATA_W'(col_q));
				mul_b = signed'({1'b0, pixel_step});
			end
			MUL_ROW_STEP: begin
				mul_a = signed'(DATA_W'(row_q));
				mul_b = signed'({1'b0, pixel_step});
			end
			MUL_RR: begin
				mul_a = signed'(zr_q);
				mul_b = signed'(zr_q);
			end
			MUL_II: begin
				mul_a = signed'(zi_q);
				mul_b = signed'(zi_q);
			end
			MUL_PR_ZR: begin
				mul_a = signed'(pr_q);
				mul_b = signed'(zr_q);
			end
			MUL_PI_ZI: begin
				mul_a = signed'(pi_q);
				mul_b = signed'(zi_q);
			end
			MUL_PR_ZI: begin
				mul_a = signed'(pr_q);
				mul_b = signed'(zi_q);
			end
			MUL_PI_ZR: begin
				mul_a = signed'(pi_q);
				mul_b = signed'(zr_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_c  = mul_a * mul_b;
	assign sum_c  = acc_q + prod_s1;
	assign diff_c = acc_q - prod_s1;

	assign stat.in_radius = sum_c < RADIUS_SQ;
	assign stat.at_limit  = cnt_q == lim_eff;

	always_ff @(posedge clk) begin
		prod_s1 <= unsigned'(mul_c);
		if (cmd.cap) begin
			col_q <= pixel_col;
			row_q <= pixel_row;
		end
		if (cmd.acc_ld)
			acc_q <= prod_s1;
		if (cmd.zr_start)
			zr_q <= prod_s1[DATA_W-1:0] + origin_x;
		if (cmd.zi_start) begin
			zi_q  <= prod_s1[DATA_W-1:0] + origin_y;
			cnt_q <= '0;
		end
		if (cmd.test)
			in_radius_q <= stat.in_radius;
		if (cmd.p_copy) begin
			pr_q <= zr_q;
			pi_q <= zi_q;
		end
		// real part: truncate Q8.56 to Q4.28 and wrap
		if (cmd.tr_ld)
			tr_q <= diff_c[FRAC_W+DATA_W-1:FRAC_W];
		if (cmd.p_ld) begin
			pr_q <= tr_q;
			pi_q <= sum_c[FRAC_W+DATA_W-1:FRAC_W];
		end
		if (cmd.z_upd) begin
			zr_q  <= pr_q + const_re;
			zi_q  <= pi_q + const_im;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.res_ld) begin
			escaped      <= ~in_radius_q;
			escape_index <= in_radius_q ? signed'({1'b0, lim_eff})
				: signed'({1'b0, cnt_q} - 12'd1);
			final_re     <= zr_q;
			final_im     <= zi_q;
		end
	end

endmodule

// ----- src/jet_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: walks start mapping, escape test and the complex-multiply chain,
// and owns both handshakes. Depends on jet_pkg; commands jet_dp.
module jet_ctrl import jet_pkg::*; #(
	parameter int MAX_POWER = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [EXP_W-1:0] exponent,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  jet_stat_t        stat,
	output jet_cmd_t         cmd
);

	localparam logic [JCNT_W-1:0] MAX_N = JCNT_W'(MAX_POWER);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ST0  = 4'd1;
	localparam logic [3:0] S_ST1  = 4'd2;
	localparam logic [3:0] S_ST2  = 4'd3;
	localparam logic [3:0] S_TS0  = 4'd4;
	localparam logic [3:0] S_TS1  = 4'd5;
	localparam logic [3:0] S_TS2  = 4'd6;
	localparam logic [3:0] S_M0   = 4'd7;
	localparam logic [3:0] S_M1   = 4'd8;
	localparam logic [3:0] S_M2   = 4'd9;
	localparam logic [3:0] S_M3   = 4'd10;
	localparam logic [3:0] S_M4   = 4'd11;
	localparam logic [3:0] S_UPD  = 4'd12;
	localparam logic [3:0] S_FIN  = 4'd13;

	logic [3:0]        state_q, state_d;
	logic [JCNT_W-1:0] j_q, j_d, n_eff, exp_w;
	logic              out_valid_q;
	logic              out_free;

	assign exp_w = JCNT_W'(exponent);
	assign n_eff = (exp_w < MIN_POWER) ? MIN_POWER : ((exp_w > MAX_N) ? MAX_N : exp_w);

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | out_ready;

	always_comb begin
		state_d     = state_q;
		j_d         = j_q;
		cmd         = '0;
		cmd.mul_sel = MUL_RR;
		unique case (state_q)
			S_IDLE: begin
				cmd.cap = in_valid;
				if (in_valid)
					state_d = S_ST0;
			end
			S_ST0: begin
				cmd.mul_sel = MUL_COL_STEP;
				state_d     = S_ST1;
			end
			S_ST1: begin
				cmd.mul_sel  = MUL_ROW_STEP;
				cmd.zr_start = 1'b1;
				state_d      = S_ST2;
			end
			S_ST2: begin
				cmd.zi_start = 1'b1;
				state_d      = S_TS0;
			end
			S_TS0: begin
				cmd.mul_sel = MUL_RR;
				state_d     = S_TS1;
			end
			S_TS1: begin
				cmd.mul_sel = MUL_II;
				cmd.acc_ld  = 1'b1;
				state_d     = S_TS2;
			end
			S_TS2: begin
				cmd.test = 1'b1;
				// stop on escape or when the update budget is spent
				if (!stat.in_radius || stat.at_limit) begin
					state_d = S_FIN;
				end else begin
					cmd.p_copy = 1'b1;
					j_d        = 5'd1;
					state_d    = S_M0;
				end
			end
			S_M0: begin
				cmd.mul_sel = MUL_PR_ZR;
				state_d     = S_M1;
			end
			S_M1: begin
				cmd.mul_sel = MUL_PI_ZI;
				cmd.acc_ld  = 1'b1;
				state_d     = S_M2;
			end
			S_M2: begin
				cmd.mul_sel = MUL_PR_ZI;
				cmd.tr_ld   = 1'b1;
				state_d     = S_M3;
			end
			S_M3: begin
				cmd.mul_sel = MUL_PI_ZR;
				cmd.acc_ld  = 1'b1;
				state_d     = S_M4;
			end
			S_M4: begin
				cmd.p_ld = 1'b1;
				if ((j_q + 5'd1) < n_eff) begin
					j_d     = j_q + 5'd1;
					state_d = S_M0;
				end else begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.z_upd = 1'b1;
				state_d   = S_TS0;
			end
			S_FIN: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			if (cmd.res_ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/jet_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the escape-time block, bound to the top level.
// Depends on the top level's ports only.
module jet_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [11:0] escape_index,
	input logic               escaped,
	input logic signed [31:0] final_re,
	input logic signed [31:0] final_im
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(escape_index)
			&& $stable(escaped) && $stable(final_re) && $stable(final_im))
		else $error("stalled result changed");

	// one request at a time: busy right after accepting
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// an index of -1 only comes from an escaped start point
	a_neg_escaped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && escape_index[11] |-> escaped)
		else $error("negative index without escape");

	// a point that stays inside reports a non-negative limit
	a_inside_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !escaped |-> !escape_index[11])
		else $error("inside point with negative index");

endmodule

bind julia_escape_time_power_n_top jet_checker u_jet_checker (.*);
